@@ src/embc_pkg.sv @@
// Shared types and constants of the 3x3 emboss convolution core.
// No dependencies; the core's top level and its result queue import this package.
package embc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 11;
  localparam int COORD_W = 10;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  // Kernel sum spans -3*255..3*255: three bits above a pixel, the top one a sign.
  localparam int SUM_W   = PIX_W + 3;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(512);
  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(3);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   value;
    logic               run_last;
    logic               frame_done;
  } res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    res = v;
    if (v < DIM_MIN) begin
      res = DIM_MIN;
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

@@ src/embc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module embc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ src/embc_res_fifo.sv @@
// Small result queue that takes up to two result items per cycle and gives one.
// Depends on embc_pkg for the result item type and the queue depth.
module embc_res_fifo import embc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push0,
  input  logic push1,
  input  res_t din0,
  input  res_t din1,
  input  logic pop,
  output res_t dout,
  output logic not_empty,
  output logic room2
);

  res_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r;
  logic [FIFO_PTR_W-1:0] rp_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic [FIFO_PTR_W-1:0] wp_inc;
  logic [FIFO_PTR_W-1:0] wp_nxt;
  logic [FIFO_CNT_W-1:0] cnt_nxt;

  assign wp_inc  = wp_r + FIFO_PTR_W'(1);
  assign wp_nxt  = wp_r + FIFO_PTR_W'(push0) + FIFO_PTR_W'(push1);
  assign cnt_nxt = cnt_r + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wp_r] <= din0;
    end
    if (push1) begin
      mem_r[wp_inc] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
      if (pop) begin
        rp_r <= rp_r + FIFO_PTR_W'(1);
      end
    end
  end

  assign dout      = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

`ifndef SYNTHESIS
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> push0)
    else $error("second result pushed without the first");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push0 |-> room2)
    else $error("result pushed into a queue without room for two");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push0 |=> cnt_r == $past(cnt_r) - FIFO_CNT_W'(1))
    else $error("queue fill level lost track of a pop");
`endif

endmodule

@@ src/emboss_3x3_convolution_core.sv @@
// Top level of the 3x3 emboss convolution core; depends on embc_pkg, embc_ram, embc_res_fifo.
// Path: an accepted item waits in stage A until the result queue has room for two, then its
// results are written into the queue and offered from it, behind any earlier results.
// Throughput: one input item per cycle while the queue has room for two; an item in the last
// row or column (row, col >= 2) causes two results; the single output port then stalls input.
// Reset (rst_n, synchronous): counters, window and queue clear, registers return to 512.
module emboss_3x3_convolution_core import embc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_W-1:0]    out_row,
  output logic [COORD_W-1:0]    out_col,
  output logic [PIX_W-1:0]      out_value,
  output logic                  out_run_last,
  output logic                  out_frame_done,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration registers.
  logic [DIM_W-1:0] line_width_r;
  logic [DIM_W-1:0] frame_height_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= DIM_RESET;
      frame_height_r <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LINE_WIDTH:   line_width_r   <= cfg_pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[DIM_W-1:0];
        default:          line_width_r   <= line_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LINE_WIDTH:   cfg_prdata = CFG_DATA_W'(line_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Position of the next input item and its classification.
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [COL_W-1:0] col_count_r;
  logic [COL_W-1:0] col_count_nxt;
  logic [ROW_W-1:0] row_count_r;
  logic [ROW_W-1:0] row_count_nxt;
  logic             in_acc;
  logic             is_last_col;
  logic             is_last_row;
  logic             is_border;
  logic             is_interior;

  assign w_eff = clamp_dim(line_width_r, DIM_W'(MAX_WIDTH));
  assign h_eff = clamp_dim(frame_height_r, DIM_W'(MAX_HEIGHT));

  assign is_last_col = DIM_W'(col_count_r) >= (w_eff - DIM_W'(1));
  assign is_last_row = DIM_W'(row_count_r) >= (h_eff - DIM_W'(1));
  assign is_border   = (row_count_r == '0) || (col_count_r == '0) || is_last_col || is_last_row;
  assign is_interior = (row_count_r >= ROW_W'(2)) && (col_count_r >= COL_W'(2));

  always_comb begin
    col_count_nxt = col_count_r + COL_W'(1);
    row_count_nxt = row_count_r;
    if (is_last_col) begin
      col_count_nxt = '0;
      row_count_nxt = is_last_row ? '0 : row_count_r + ROW_W'(1);
    end
  end

  // Stage A holds the accepted item while the line store answers.
  logic             a_valid_r;
  logic [PIX_W-1:0] a_pix_r;
  logic [COL_W-1:0] a_col_r;
  logic [ROW_W-1:0] a_row_r;
  logic             a_last_col_r;
  logic             a_last_row_r;
  logic             a_border_r;
  logic             a_interior_r;
  logic             a_adv;
  logic             fifo_room2;

  assign a_adv    = a_valid_r && fifo_room2;
  assign in_ready = !a_valid_r || a_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      col_count_r <= '0;
      row_count_r <= '0;
    end else begin
      if (in_acc) begin
        a_valid_r   <= 1'b1;
        col_count_r <= col_count_nxt;
        row_count_r <= row_count_nxt;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pix_r      <= in_pixel_in;
      a_col_r      <= col_count_r;
      a_row_r      <= row_count_r;
      a_last_col_r <= is_last_col;
      a_last_row_r <= is_last_row;
      a_border_r   <= is_border;
      a_interior_r <= is_interior;
    end
  end

  // Each line store entry holds the pixels two rows up (upper byte) and one row up.
  logic [2*PIX_W-1:0] ls_rdata;
  logic [PIX_W-1:0]   top;
  logic [PIX_W-1:0]   mid;

  embc_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (a_adv),
    .waddr (a_col_r),
    .wdata ({mid, a_pix_r}),
    .re    (in_acc),
    .raddr (col_count_r),
    .rdata (ls_rdata)
  );

  assign top = ls_rdata[2*PIX_W-1:PIX_W];
  assign mid = ls_rdata[PIX_W-1:0];

  // Window: two previous columns of the top and middle rows, and the previous bottom
  // pixel. The older bottom pixel never enters the kernel, so it is not kept.
  logic [PIX_W-1:0] win0_r;
  logic [PIX_W-1:0] win1_r;
  logic [PIX_W-1:0] win2_r;
  logic [PIX_W-1:0] win3_r;
  logic [PIX_W-1:0] win5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
      win2_r <= '0;
      win3_r <= '0;
      win5_r <= '0;
    end else if (a_adv) begin
      win0_r <= win1_r;
      win1_r <= top;
      win2_r <= win3_r;
      win3_r <= mid;
      win5_r <= a_pix_r;
    end
  end

  logic [SUM_W-1:0] sum;
  logic [PIX_W-1:0] filt;

  assign sum = SUM_W'(mid) + SUM_W'(win5_r) + SUM_W'(a_pix_r)
             - SUM_W'(win0_r) - SUM_W'(win1_r) - SUM_W'(win2_r);

  always_comb begin
    if (sum[SUM_W-1]) begin
      filt = '0;
    end else if (sum[SUM_W-2:PIX_W] != '0) begin
      filt = '1;
    end else begin
      filt = sum[PIX_W-1:0];
    end
  end

  res_t res_int;
  res_t res_bord;
  res_t res0;
  logic push0;
  logic push1;
  res_t fifo_dout;
  logic fifo_ne;
  logic out_pop;

  always_comb begin
    res_int.row        = COORD_W'(a_row_r - ROW_W'(1));
    res_int.col        = COORD_W'(a_col_r - COL_W'(1));
    res_int.value      = filt;
    res_int.run_last   = !a_border_r;
    res_int.frame_done = 1'b0;
    res_bord.row        = COORD_W'(a_row_r);
    res_bord.col        = COORD_W'(a_col_r);
    res_bord.value      = a_pix_r;
    res_bord.run_last   = 1'b1;
    res_bord.frame_done = a_last_row_r && a_last_col_r;
  end

  assign res0  = a_interior_r ? res_int : res_bord;
  assign push0 = a_adv && (a_interior_r || a_border_r);
  assign push1 = a_adv && a_interior_r && a_border_r;

  assign out_pop = out_valid && out_ready;

  embc_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .din0      (res0),
    .din1      (res_bord),
    .pop       (out_pop),
    .dout      (fifo_dout),
    .not_empty (fifo_ne),
    .room2     (fifo_room2)
  );

  assign out_valid      = fifo_ne;
  assign out_row        = fifo_dout.row;
  assign out_col        = fifo_dout.col;
  assign out_value      = fifo_dout.value;
  assign out_run_last   = fifo_dout.run_last;
  assign out_frame_done = fifo_dout.frame_done;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !a_adv |=> a_valid_r && $stable(a_col_r) && $stable(a_pix_r))
    else $error("stalled item in stage A was lost or changed");
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_last_row && is_last_col |=> row_count_r == '0 && col_count_r == '0)
    else $error("counters did not wrap at the end of the frame");
  a_read_write_apart: assert property (@(posedge clk) disable iff (!rst_n)
    a_adv && in_acc |-> a_col_r != col_count_r)
    else $error("line store read and write hit the same entry in one cycle");
`endif

endmodule
